>>> hw/rtl/nxc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nxc_pkg
// Shared widths, codes and types for the normalized cross-correlation lag
// search.
// ----------------------------------------------------------------------------
package nxc_pkg;

	localparam int VIDEO_DEPTH = 4096;
	localparam int REF_DEPTH   = 16384;

	localparam int VADDR_W = $clog2(VIDEO_DEPTH);
	localparam int RADDR_W = $clog2(REF_DEPTH);
	localparam int VLEN_W  = VADDR_W + 1;
	localparam int RLEN_W  = RADDR_W + 1;

	localparam int FUNC_W     = 2;
	localparam int SAMPLE_W   = 16;
	localparam int LAG_W      = 15;
	localparam int SCORE_W    = 16;
	localparam int OVL_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// signed arithmetic on lags and lengths
	localparam int CALC_W = ((RLEN_W > LAG_W) ? RLEN_W : LAG_W) + 2;

	// sums of Q8.24 products over at most VIDEO_DEPTH samples
	localparam int ACC_W   = 2 * SAMPLE_W - 1 + VADDR_W;
	localparam int DOT_W   = ACC_W + 1;
	localparam int PROD_W  = 2 * ACC_W;
	localparam int FRAC_SH = 2 * (SCORE_W - 1);
	localparam int DIV_W   = PROD_W + FRAC_SH;
	localparam int QUO_W   = FRAC_SH + 1;
	localparam int MAG_W   = SCORE_W;
	localparam int ITER_W  = $clog2(DIV_W) + 1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_VIDEO  = 2'd0,
		FUNC_REF    = 2'd1,
		FUNC_SEARCH = 2'd2
	} func_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAG     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OVERLAP = 2'd2;

endpackage
`default_nettype wire

>>> hw/rtl/nxc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nxc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module nxc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/nxc_score.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nxc_score
// Multi-cycle score magnitude: floor(2^15 * |dot| / sqrt(ev * er)) through
// shift-add products, restoring division and a bitwise square root.
// ----------------------------------------------------------------------------
module nxc_score (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire signed [nxc_pkg::DOT_W-1:0]  dot,
	input  wire        [nxc_pkg::ACC_W-1:0]  ev,
	input  wire        [nxc_pkg::ACC_W-1:0]  er,
	output logic                             done,
	output logic       [nxc_pkg::MAG_W-1:0]  mag
);

	typedef enum logic [4:0] {
		SC_IDLE  = 5'b00001,
		SC_MUL_P = 5'b00010,
		SC_MUL_S = 5'b00100,
		SC_DIV   = 5'b01000,
		SC_SQRT  = 5'b10000
	} sc_state_t;

	sc_state_t                     state_q;
	logic [nxc_pkg::PROD_W-1:0]    a_q;
	logic [nxc_pkg::ACC_W-1:0]     b_q;
	logic [nxc_pkg::PROD_W-1:0]    acc_q;
	logic [nxc_pkg::PROD_W-1:0]    p_q;
	logic [nxc_pkg::ACC_W-1:0]     absdot_q;
	logic [nxc_pkg::DIV_W-1:0]     rem_q;
	logic [nxc_pkg::DIV_W-1:0]     div_q;
	logic [nxc_pkg::QUO_W-1:0]     quo_q;
	logic [nxc_pkg::MAG_W-1:0]     root_q;
	logic [nxc_pkg::MAG_W-1:0]     bit_q;
	logic [nxc_pkg::ITER_W-1:0]    iter_q;

	logic [nxc_pkg::PROD_W-1:0]    acc_next;
	logic [nxc_pkg::DOT_W-1:0]     dot_neg;
	logic [nxc_pkg::MAG_W-1:0]     trial;
	logic [2*nxc_pkg::MAG_W-1:0]   trial_sq;
	logic                          div_fits;
	logic                          mul_last;

	assign acc_next = b_q[0] ? acc_q + a_q : acc_q;
	assign mul_last = (iter_q == nxc_pkg::ITER_W'(nxc_pkg::ACC_W - 1));
	assign dot_neg  = -dot;
	assign div_fits = (div_q <= rem_q);
	assign trial    = root_q | bit_q;
	assign trial_sq = trial * trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						state_q <= SC_MUL_P;
					end
				end
				SC_MUL_P: begin
					if (mul_last) begin
						state_q <= SC_MUL_S;
					end
				end
				SC_MUL_S: begin
					if (mul_last) begin
						state_q <= SC_DIV;
					end
				end
				SC_DIV: begin
					if (iter_q == nxc_pkg::ITER_W'(nxc_pkg::QUO_W - 1)) begin
						state_q <= SC_SQRT;
					end
				end
				SC_SQRT: begin
					if (bit_q[0]) begin
						state_q <= SC_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				a_q      <= nxc_pkg::PROD_W'(ev);
				b_q      <= er;
				acc_q    <= '0;
				iter_q   <= '0;
				absdot_q <= dot[nxc_pkg::DOT_W-1] ? dot_neg[nxc_pkg::ACC_W-1:0]
				                                  : dot[nxc_pkg::ACC_W-1:0];
			end
			SC_MUL_P: begin
				if (mul_last) begin
					p_q    <= acc_next;
					a_q    <= nxc_pkg::PROD_W'(absdot_q);
					b_q    <= absdot_q;
					acc_q  <= '0;
					iter_q <= '0;
				end else begin
					acc_q  <= acc_next;
					a_q    <= a_q << 1;
					b_q    <= b_q >> 1;
					iter_q <= iter_q + 1'b1;
				end
			end
			SC_MUL_S: begin
				if (mul_last) begin
					rem_q  <= {acc_next, {nxc_pkg::FRAC_SH{1'b0}}};
					div_q  <= {p_q, {nxc_pkg::FRAC_SH{1'b0}}};
					quo_q  <= '0;
					iter_q <= '0;
				end else begin
					acc_q  <= acc_next;
					a_q    <= a_q << 1;
					b_q    <= b_q >> 1;
					iter_q <= iter_q + 1'b1;
				end
			end
			SC_DIV: begin
				if (div_fits) begin
					rem_q <= rem_q - div_q;
				end
				quo_q  <= {quo_q[nxc_pkg::QUO_W-2:0], div_fits};
				div_q  <= div_q >> 1;
				iter_q <= iter_q + 1'b1;
				root_q <= '0;
				bit_q  <= {1'b1, {(nxc_pkg::MAG_W-1){1'b0}}};
			end
			SC_SQRT: begin
				if (trial_sq <= (2*nxc_pkg::MAG_W)'(quo_q)) begin
					root_q <= trial;
					if (bit_q[0]) begin
						mag <= trial;
					end
				end else if (bit_q[0]) begin
					mag <= root_q;
				end
				bit_q <= bit_q >> 1;
			end
			default: begin
				iter_q <= '0;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/normalized_xcorr_lag_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_xcorr_lag_search
// Loads video and reference envelopes into two RAMs and searches the lag
// with the highest normalized cross-correlation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, func, sample): a video or reference
//   item appends sample to its RAM at one item per cycle; items beyond the
//   RAM depth are dropped. A search item scores min_lag..max_lag, posts one
//   result item (best_lag, score, found) and empties both envelopes.
//   Each lag passes a setup and a step state; a lag with enough overlap
//   also streams count sample pairs from the RAMs (one sample pair per
//   cycle) and, with both energies nonzero, runs the score unit. The
//   result is posted from the final state once the output is free.
//   in_ready is low during a search. A stalled result does not block loads; the
//   next search holds its result, with in_ready low, until the first is taken.
//   Configuration is always ready; write it only while idle. Reset clears
//   lengths, registers and output valid, not RAM contents.
// ----------------------------------------------------------------------------
module normalized_xcorr_lag_search (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire        [nxc_pkg::FUNC_W-1:0]    func,
	input  wire signed [nxc_pkg::SAMPLE_W-1:0]  sample,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [nxc_pkg::LAG_W-1:0]    best_lag,
	output logic signed [nxc_pkg::SCORE_W-1:0]  score,
	output logic                                found,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire        [nxc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire        [nxc_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LAG   = 7'b0000010,
		ST_ACC   = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_SCORE = 7'b0010000,
		ST_NEXT  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	localparam int CW = nxc_pkg::CALC_W;

	state_t                              state_q;
	logic signed [nxc_pkg::LAG_W-1:0]    min_lag_q;
	logic signed [nxc_pkg::LAG_W-1:0]    max_lag_q;
	logic        [nxc_pkg::OVL_W-1:0]    min_overlap_q;
	logic        [nxc_pkg::VLEN_W-1:0]   vlen_q;
	logic        [nxc_pkg::RLEN_W-1:0]   rlen_q;
	logic signed [nxc_pkg::LAG_W-1:0]    lag_q;
	logic        [nxc_pkg::VADDR_W-1:0]  va_q;
	logic        [nxc_pkg::RADDR_W-1:0]  ra_q;
	logic        [nxc_pkg::VLEN_W-1:0]   left_q;
	logic signed [nxc_pkg::DOT_W-1:0]    dot_q;
	logic        [nxc_pkg::ACC_W-1:0]    ev_q;
	logic        [nxc_pkg::ACC_W-1:0]    er_q;
	logic                                hit_q;
	logic signed [nxc_pkg::LAG_W-1:0]    hit_lag_q;
	logic signed [nxc_pkg::SCORE_W-1:0]  hit_score_q;
	logic                                sc_start_q;
	logic                                rd_s1;
	logic                                vld_s2;
	logic signed [2*nxc_pkg::SAMPLE_W-1:0] pvr_s2;
	logic        [2*nxc_pkg::SAMPLE_W-1:0] pvv_s2;
	logic        [2*nxc_pkg::SAMPLE_W-1:0] prr_s2;
	logic                                out_valid_q;

	logic                                in_acc;
	logic                                vid_we;
	logic                                ref_we;
	logic        [nxc_pkg::SAMPLE_W-1:0] vid_rdata;
	logic        [nxc_pkg::SAMPLE_W-1:0] ref_rdata;
	logic signed [CW-1:0]                lag_ext;
	logic signed [CW-1:0]                vstart;
	logic signed [CW-1:0]                rstart;
	logic signed [CW-1:0]                cnt_v;
	logic signed [CW-1:0]                cnt_r;
	logic signed [CW-1:0]                cnt;
	logic                                lag_ok;
	logic                                sc_done;
	logic        [nxc_pkg::MAG_W-1:0]    sc_mag;
	logic        [nxc_pkg::MAG_W:0]      mag_neg;
	logic signed [nxc_pkg::SCORE_W-1:0]  sc_val;
	logic                                post;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	assign vid_we = in_acc && (func == nxc_pkg::FUNC_VIDEO)
	                && (vlen_q < nxc_pkg::VLEN_W'(nxc_pkg::VIDEO_DEPTH));
	assign ref_we = in_acc && (func == nxc_pkg::FUNC_REF)
	                && (rlen_q < nxc_pkg::RLEN_W'(nxc_pkg::REF_DEPTH));

	nxc_ram #(
		.WIDTH(nxc_pkg::SAMPLE_W),
		.DEPTH(nxc_pkg::VIDEO_DEPTH)
	) u_video_ram (
		.clk   (clk),
		.we    (vid_we),
		.waddr (vlen_q[nxc_pkg::VADDR_W-1:0]),
		.wdata (sample),
		.raddr (va_q),
		.rdata (vid_rdata)
	);

	nxc_ram #(
		.WIDTH(nxc_pkg::SAMPLE_W),
		.DEPTH(nxc_pkg::REF_DEPTH)
	) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (rlen_q[nxc_pkg::RADDR_W-1:0]),
		.wdata (sample),
		.raddr (ra_q),
		.rdata (ref_rdata)
	);

	nxc_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start_q),
		.dot    (dot_q),
		.ev     (ev_q),
		.er     (er_q),
		.done   (sc_done),
		.mag    (sc_mag)
	);

	// Overlap of the two envelopes at the current lag.
	always_comb begin
		lag_ext = CW'(lag_q);
		vstart  = lag_q[nxc_pkg::LAG_W-1] ? -lag_ext : '0;
		rstart  = (!lag_q[nxc_pkg::LAG_W-1] && (lag_q != '0)) ? lag_ext : '0;
		cnt_v   = CW'(vlen_q) - vstart;
		cnt_r   = CW'(rlen_q) - rstart;
		cnt     = (cnt_r < cnt_v) ? cnt_r : cnt_v;
		lag_ok  = !cnt[CW-1] && (cnt != '0) && (cnt >= $signed(CW'(min_overlap_q)));
	end

	// Signed Q1.15 score; positive full scale saturates.
	always_comb begin
		mag_neg = -{1'b0, sc_mag};
		if (dot_q[nxc_pkg::DOT_W-1]) begin
			sc_val = mag_neg[nxc_pkg::SCORE_W-1:0];
		end else if (sc_mag[nxc_pkg::MAG_W-1]) begin
			sc_val = {1'b0, {(nxc_pkg::SCORE_W-1){1'b1}}};
		end else begin
			sc_val = sc_mag;
		end
	end

	assign post = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Control: state, lengths, configuration, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			min_lag_q     <= '0;
			max_lag_q     <= '0;
			min_overlap_q <= nxc_pkg::OVL_W'(1);
			vlen_q        <= '0;
			rlen_q        <= '0;
			out_valid_q   <= 1'b0;
			sc_start_q    <= 1'b0;
			rd_s1         <= 1'b0;
			vld_s2        <= 1'b0;
		end else begin
			sc_start_q <= 1'b0;
			rd_s1      <= (state_q == ST_ACC);
			vld_s2     <= rd_s1;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					nxc_pkg::CFG_MIN_LAG:     min_lag_q <= cfg_data;
					nxc_pkg::CFG_MAX_LAG:     max_lag_q <= cfg_data;
					nxc_pkg::CFG_MIN_OVERLAP: min_overlap_q <= cfg_data[nxc_pkg::OVL_W-1:0];
					default: ;
				endcase
			end

			if (vid_we) begin
				vlen_q <= vlen_q + 1'b1;
			end
			if (ref_we) begin
				rlen_q <= rlen_q + 1'b1;
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (post) begin
				out_valid_q <= 1'b1;
				vlen_q      <= '0;
				rlen_q      <= '0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && (func == nxc_pkg::FUNC_SEARCH)) begin
						state_q <= (min_lag_q > max_lag_q) ? ST_FIN : ST_LAG;
					end
				end
				ST_LAG: begin
					state_q <= lag_ok ? ST_ACC : ST_NEXT;
				end
				ST_ACC: begin
					if (left_q == nxc_pkg::VLEN_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_s1 && !vld_s2) begin
						if ((ev_q == '0) || (er_q == '0)) begin
							state_q <= ST_NEXT;
						end else begin
							state_q    <= ST_SCORE;
							sc_start_q <= 1'b1;
						end
					end
				end
				ST_SCORE: begin
					if (sc_done) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					state_q <= (lag_q == max_lag_q) ? ST_FIN : ST_LAG;
				end
				ST_FIN: begin
					if (post) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: lag walk, RAM streaming, accumulation, best tracking.
	always_ff @(posedge clk) begin
		pvr_s2 <= $signed(vid_rdata) * $signed(ref_rdata);
		pvv_s2 <= $signed(vid_rdata) * $signed(vid_rdata);
		prr_s2 <= $signed(ref_rdata) * $signed(ref_rdata);

		if (vld_s2) begin
			dot_q <= dot_q + nxc_pkg::DOT_W'(pvr_s2);
			ev_q  <= ev_q + nxc_pkg::ACC_W'(pvv_s2);
			er_q  <= er_q + nxc_pkg::ACC_W'(prr_s2);
		end

		case (state_q)
			ST_IDLE: begin
				lag_q <= min_lag_q;
				hit_q <= 1'b0;
			end
			ST_LAG: begin
				va_q   <= vstart[nxc_pkg::VADDR_W-1:0];
				ra_q   <= rstart[nxc_pkg::RADDR_W-1:0];
				left_q <= cnt[nxc_pkg::VLEN_W-1:0];
				dot_q  <= '0;
				ev_q   <= '0;
				er_q   <= '0;
			end
			ST_ACC: begin
				va_q   <= va_q + 1'b1;
				ra_q   <= ra_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			ST_SCORE: begin
				if (sc_done && (!hit_q || (sc_val > hit_score_q))) begin
					hit_q       <= 1'b1;
					hit_score_q <= sc_val;
					hit_lag_q   <= lag_q;
				end
			end
			ST_NEXT: begin
				lag_q <= lag_q + 1'b1;
			end
			default: ;
		endcase

		if (post) begin
			found    <= hit_q;
			best_lag <= hit_q ? hit_lag_q : '0;
			score    <= hit_q ? hit_score_q : '0;
		end
	end

endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - lag search testbench
// Streams video and reference envelope loads and search items into the
// block, predicts each search's best lag, score and found flag in Q1.15
// fixed point, and checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nxc_pkg::*;

	// unused function code: the block must ignore it
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0]          fn;
		logic signed [SAMPLE_W-1:0] smp;
	} load_item_t;

	typedef struct {
		logic signed [LAG_W-1:0]   lag;
		logic signed [SCORE_W-1:0] scr;
		logic                      hit;
	} lag_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [LAG_W-1:0] best_lag;
	logic signed [SCORE_W-1:0] score;
	logic found;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	normalized_xcorr_lag_search dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.best_lag(best_lag), .score(score), .found(found),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// shadow state of the block
	logic signed [SAMPLE_W-1:0] video_env [VIDEO_DEPTH];
	logic signed [SAMPLE_W-1:0] ref_env [REF_DEPTH];
	int video_len;
	int ref_len;
	int lag_lo;
	int lag_hi;
	int overlap_floor;

	load_item_t  pending_loads[$];
	lag_result_t expected_lags[$];
	int mismatches;
	bit calm;	// when set, neither side idles

	// Score one lag. ok is low for a short overlap or a silent envelope.
	function automatic void score_lag(input int lag, output bit ok, output int scr);
		int vstart, rstart, cnt;
		longint dot, ev, er, v, r;
		logic [127:0] energy, corr, mag;
		int lo, hi, mid;
		vstart = lag < 0 ? -lag : 0;
		rstart = lag > 0 ? lag : 0;
		cnt = video_len - vstart;
		if (ref_len - rstart < cnt)
			cnt = ref_len - rstart;
		ok = 0;
		scr = 0;
		if (cnt <= 0 || cnt < overlap_floor)
			return;
		dot = 0;
		ev = 0;
		er = 0;
		for (int i = 0; i < cnt; i++) begin
			v = video_env[vstart + i];
			r = ref_env[rstart + i];
			dot += v * r;
			ev += v * v;
			er += r * r;
		end
		if (ev == 0 || er == 0)
			return;
		energy = 128'(ev);
		energy = energy * 128'(er);
		mag = 128'(dot < 0 ? -dot : dot);
		corr = (mag * mag) << 30;
		// largest magnitude whose square times the energies fits the product
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (energy * 128'(mid) * 128'(mid) <= corr)
				lo = mid;
			else
				hi = mid - 1;
		end
		ok = 1;
		if (dot < 0)
			scr = -lo;
		else
			scr = lo > 32767 ? 32767 : lo;
	endfunction

	// Apply one accepted item to the shadow state; a search queues its result.
	function automatic void predict_item(load_item_t it);
		lag_result_t res;
		bit ok, hit;
		int scr, best, best_at;
		case (it.fn)
			FUNC_VIDEO: begin
				if (video_len < VIDEO_DEPTH) begin
					video_env[video_len] = it.smp;
					video_len++;
				end
			end
			FUNC_REF: begin
				if (ref_len < REF_DEPTH) begin
					ref_env[ref_len] = it.smp;
					ref_len++;
				end
			end
			FUNC_SEARCH: begin
				hit = 0;
				best = 0;
				best_at = 0;
				for (int lag = lag_lo; lag <= lag_hi; lag++) begin
					score_lag(lag, ok, scr);
					// strictly greater: the earliest lag keeps a tie
					if (ok && (!hit || scr > best)) begin
						hit = 1;
						best = scr;
						best_at = lag;
					end
				end
				video_len = 0;
				ref_len = 0;
				res.lag = LAG_W'(best_at);
				res.scr = SCORE_W'(best);
				res.hit = hit;
				expected_lags.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// Driver: present the next pending item, predict it when accepted.
	always @(posedge clk or negedge arst_n) begin
		bit take;
		load_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			take = !in_valid;
			if (in_valid && in_ready) begin
				it.fn = func;
				it.smp = sample;
				predict_item(it);
				take = 1;
			end
			if (take) begin
				if (pending_loads.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
					it = pending_loads.pop_front();
					in_valid <= 1'b1;
					func <= it.fn;
					sample <= it.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	// Monitor: stall the output at random, check each result taken.
	always @(posedge clk or negedge arst_n) begin
		lag_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lags.size() == 0) begin
					report("result with no search pending, lag", best_lag, 0);
				end else begin
					want = expected_lags.pop_front();
					if (found !== want.hit)
						report("found", found, want.hit);
					if (best_lag !== want.lag)
						report("best_lag", best_lag, want.lag);
					if (score !== want.scr)
						report("score", score, want.scr);
				end
			end
			out_ready <= calm || $urandom_range(99) >= 25;
		end
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MIN_LAG: lag_lo = value;
			CFG_MAX_LAG: lag_hi = value;
			default: overlap_floor = value;
		endcase
	endtask

	task automatic set_search(int lo, int hi, int ovl);
		cfg_write(CFG_MIN_LAG, lo);
		cfg_write(CFG_MAX_LAG, hi);
		cfg_write(CFG_MIN_OVERLAP, ovl);
	endtask

	task automatic add(logic [FUNC_W-1:0] fn, int smp);
		load_item_t it;
		it.fn = fn;
		it.smp = SAMPLE_W'(smp);
		pending_loads.push_back(it);
	endtask

	// Hold until every item is taken and every result is back, then let
	// any load still in flight settle.
	task automatic settle();
		while (pending_loads.size() > 0 || in_valid || expected_lags.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic int rand_sample();
		case ($urandom_range(7))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(64) - 32;
			default: return $signed(16'($urandom));
		endcase
	endfunction

	initial begin
		int produced, nv, nr, style, shift, lo;
		int vbuf[$];
		int rbuf[$];
		lag_lo = 0;
		lag_hi = 0;
		overlap_floor = 1;
		video_len = 0;
		ref_len = 0;
		mismatches = 0;
		calm = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, empty envelopes, extremes, silence, negation
		add(FUNC_SEARCH, 0);
		add(FUNC_VIDEO, 32767);
		add(FUNC_VIDEO, -32768);
		add(FUNC_VIDEO, 16'sh1234);
		add(FUNC_REF, 32767);
		add(FUNC_REF, -32768);
		add(FUNC_REF, 16'sh1234);
		add(FUNC_NONE, -1);
		add(FUNC_SEARCH, -1);
		add(FUNC_VIDEO, 5);
		add(FUNC_VIDEO, -7);
		add(FUNC_REF, 0);
		add(FUNC_REF, 0);
		add(FUNC_SEARCH, 0);
		add(FUNC_VIDEO, 300);
		add(FUNC_VIDEO, -300);
		add(FUNC_REF, -300);
		add(FUNC_REF, 300);
		add(FUNC_SEARCH, 0);
		settle();

		// empty lag range, then a wide range from -4096 to 16383
		set_search(3, 2, 1);
		add(FUNC_VIDEO, 100);
		add(FUNC_REF, 100);
		add(FUNC_SEARCH, 0);
		settle();
		set_search(-4096, 16383, 0);
		for (int i = 0; i < 8; i++) begin
			add(FUNC_VIDEO, rand_sample());
			add(FUNC_REF, rand_sample());
		end
		add(FUNC_SEARCH, 0);
		settle();

		// full memories: overflow both, overlap floor at the full video depth
		calm = 1;
		set_search(-2, 2, 4096);
		for (int i = 0; i < VIDEO_DEPTH + 4; i++) begin
			add(FUNC_VIDEO, rand_sample());
			add(FUNC_REF, rand_sample());
		end
		add(FUNC_SEARCH, 0);
		settle();
		calm = 0;
		set_search(16378, 16383, 1);
		for (int i = 0; i < 10; i++)
			add(FUNC_VIDEO, rand_sample());
		for (int i = 0; i < REF_DEPTH + 6; i++)
			add(FUNC_REF, rand_sample());
		add(FUNC_SEARCH, 0);
		settle();
		set_search(-4096, -4090, 1);
		for (int i = 0; i < VIDEO_DEPTH + 3; i++)
			add(FUNC_VIDEO, rand_sample());
		for (int i = 0; i < 10; i++)
			add(FUNC_REF, rand_sample());
		add(FUNC_SEARCH, 0);
		settle();

		// random phases: load two envelopes, search a small lag window
		produced = 0;
		for (int ph = 0; produced < 1750; ph++) begin
			calm = (ph % 6 == 5);
			lo = int'($urandom_range(50)) - 20;
			if ($urandom_range(9) == 0)
				set_search(lo, lo - 1 - int'($urandom_range(3)), 1);
			else if ($urandom_range(9) == 0)
				set_search(lo, lo + int'($urandom_range(12)), $urandom_range(4096));
			else
				set_search(lo, lo + int'($urandom_range(12)), $urandom_range(6));
			nv = $urandom_range(40);
			nr = $urandom_range(60);
			style = $urandom_range(9);
			shift = $urandom_range(5);
			vbuf.delete();
			rbuf.delete();
			for (int i = 0; i < nv; i++)
				vbuf.push_back(style == 0 ? 0 : rand_sample());
			for (int i = 0; i < nr; i++) begin
				if (style == 1)
					rbuf.push_back(0);
				else if (style >= 2 && style <= 4 && i >= shift && i - shift < nv)
					// copy or negate the video for a strong match at lag shift
					rbuf.push_back(style == 3 ? (vbuf[i - shift] == -32768 ? 32767
						: -vbuf[i - shift]) : vbuf[i - shift]);
				else
					rbuf.push_back(rand_sample());
			end
			// interleave the two streams at random
			while (vbuf.size() > 0 || rbuf.size() > 0) begin
				if (rbuf.size() == 0 || (vbuf.size() > 0 && $urandom_range(1)))
					add(FUNC_VIDEO, vbuf.pop_front());
				else
					add(FUNC_REF, rbuf.pop_front());
				produced++;
				if ($urandom_range(99) < 3)
					add(FUNC_NONE, rand_sample());
			end
			add(FUNC_SEARCH, rand_sample());
			produced++;
			if ($urandom_range(7) == 0) begin
				add(FUNC_SEARCH, 0);
				produced++;
			end
			settle();
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/nxc_pkg.sv
hw/rtl/nxc_ram.sv
hw/rtl/nxc_score.sv
hw/rtl/normalized_xcorr_lag_search.sv
tb/tb.sv
